// ----- rtl/core/gcsm_pkg.sv -----
// gcsm_pkg: shared types, codes and default sizes for the stack-map lookup block
// no dependencies; used by the interfaces, the sequencer and the top level
package gcsm_pkg;

  localparam int unsigned NumPointsDef     = 256;
  localparam int unsigned DataWordsDef     = 1024;
  localparam int unsigned BaseWordsDef     = 1024;
  localparam int unsigned MaxRegsDef       = 64;
  localparam int unsigned DescBitsDef      = 6;
  localparam int unsigned MaxStackSlotsDef = 32;

  // descriptor word 0 flag positions
  localparam int unsigned FlagRegsNone  = 31;
  localparam int unsigned FlagRegsSame  = 30;
  localparam int unsigned FlagStackNone = 29;
  localparam int unsigned FlagStackSame = 28;

  localparam logic [6:0] NumRegsReset = 7'd32;
  localparam logic [8:0] EntriesReset = 9'd0;

  typedef enum logic [1:0] {
    OpWrIndex = 2'd0,
    OpWrData  = 2'd1,
    OpWrBase  = 2'd2,
    OpQuery   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KindNotFound = 2'd0,
    KindRegMap   = 2'd1,
    KindStackOff = 2'd2,
    KindWrAck    = 2'd3
  } kind_e;

  typedef enum logic {
    CfgNumRegs      = 1'b0,
    CfgEntriesInUse = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_REDUCE, S_WRITE, S_SRCH_RD, S_SRCH_CMP, S_RES_RDP, S_RES_RDD,
    S_RES_CHK, S_BASE_RD, S_BASE_CHK, S_SCAN_RD, S_SCAN_LAT, S_SCAN_BIT,
    S_SCAN_OFF, S_PUSH_MID, S_SCAN_ADV, S_PUSH_END
  } state_e;

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  reg_bitmap;
    logic [31:0]  stack_offset;
  } result_t;

endpackage

// ----- rtl/core/gcsm_if.sv -----
// gcsm channel interfaces: input items, result items and configuration writes
// depends on gcsm_pkg for the opcode and kind codes
interface gcsm_in_if;
  logic             valid;
  logic             ready;
  gcsm_pkg::op_e    opcode;
  logic [9:0]       slot;
  logic [31:0]      pc;
  logic [31:0]      word;
  logic [9:0]       data_ptr;
  logic [9:0]       base_ptr;
  modport source (output valid, opcode, slot, pc, word, data_ptr, base_ptr, input ready);
  modport sink   (input valid, opcode, slot, pc, word, data_ptr, base_ptr, output ready);
endinterface

interface gcsm_out_if;
  logic                valid;
  logic                ready;
  gcsm_pkg::kind_e     kind;
  logic [63:0]         reg_bitmap;
  logic signed [31:0]  stack_offset;
  logic                last;
  modport source (output valid, kind, reg_bitmap, stack_offset, last, input ready);
  modport sink   (input valid, kind, reg_bitmap, stack_offset, last, output ready);
endinterface

interface gcsm_cfg_if;
  logic                 valid;
  logic                 ready;
  gcsm_pkg::cfg_idx_e   index;
  logic [8:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gcsm_ram.sv -----
// gcsm_ram: single-port-write, single-port-read synchronous memory, registered read
// no dependencies
module gcsm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/gcsm_ctrl.sv -----
// gcsm_ctrl: lookup sequencer: search, flag walk-back, bit scan and result register
// depends on gcsm_pkg; drives the point, descriptor and base memories in the top level
module gcsm_ctrl #(
  parameter int unsigned NumPoints     = gcsm_pkg::NumPointsDef,
  parameter int unsigned DataWords     = gcsm_pkg::DataWordsDef,
  parameter int unsigned BaseWords     = gcsm_pkg::BaseWordsDef,
  parameter int unsigned MaxRegs       = gcsm_pkg::MaxRegsDef,
  parameter int unsigned DescBits      = gcsm_pkg::DescBitsDef,
  parameter int unsigned MaxStackSlots = gcsm_pkg::MaxStackSlotsDef,
  localparam int unsigned PAW = $clog2(NumPoints),
  localparam int unsigned DAW = $clog2(DataWords),
  localparam int unsigned BAW = $clog2(BaseWords),
  localparam int unsigned PW  = 32 + DAW + BAW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gcsm_pkg::op_e       in_opcode_i,
  input  logic [9:0]          in_slot_i,
  input  logic [31:0]         in_pc_i,
  input  logic [31:0]         in_word_i,
  input  logic [9:0]          in_data_ptr_i,
  input  logic [9:0]          in_base_ptr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gcsm_pkg::result_t   out_res_o,
  output logic                out_last_o,
  input  logic [6:0]          num_regs_i,
  input  logic [8:0]          entries_i,
  output logic                pt_we_o,
  output logic [PAW-1:0]      pt_waddr_o,
  output logic [PW-1:0]       pt_wdata_o,
  output logic [PAW-1:0]      pt_raddr_o,
  input  logic [PW-1:0]       pt_rdata_i,
  output logic                ds_we_o,
  output logic [DAW-1:0]      ds_waddr_o,
  output logic [31:0]         ds_wdata_o,
  output logic [DAW-1:0]      ds_raddr_o,
  input  logic [31:0]         ds_rdata_i,
  output logic                bs_we_o,
  output logic [BAW-1:0]      bs_waddr_o,
  output logic [31:0]         bs_wdata_o,
  output logic [BAW-1:0]      bs_raddr_o,
  input  logic [31:0]         bs_rdata_i
);

  localparam int unsigned CW = PAW + 1;

  function automatic logic [DAW-1:0] d_wrap_add(input logic [DAW-1:0] a, input logic [2:0] b);
    logic [DAW:0] s;
    s = {1'b0, a} + (DAW+1)'(b);
    if (s >= (DAW+1)'(DataWords)) s = s - (DAW+1)'(DataWords);
    return s[DAW-1:0];
  endfunction

  function automatic logic [BAW-1:0] b_wrap_inc(input logic [BAW-1:0] a);
    logic [BAW:0] s;
    s = {1'b0, a} + (BAW+1)'(1);
    if (s >= (BAW+1)'(BaseWords)) s = '0;
    return s[BAW-1:0];
  endfunction

  gcsm_pkg::state_e state_q, state_d;
  logic             stack_q;
  logic             out_valid_q;

  gcsm_pkg::op_e    op_q;
  logic [9:0]       slot_q;
  logic [31:0]      pc_q;
  logic [31:0]      wword_q;
  logic [9:0]       dp_q, bp_q;
  logic [CW-1:0]    left_q, rp1_q;
  logic [PAW-1:0]   entry_q, cur_q;
  logic [DAW-1:0]   dstart_q;
  logic [BAW-1:0]   bstart_q, kaddr_q;
  logic             regs_flag_q;
  logic [7:0]       pos_q;
  logic [6:0]       cnt_q;
  logic [5:0]       idx_q;
  logic [31:0]      sword_q;
  logic [63:0]      bitmap_q;
  logic [31:0]      new_q;
  gcsm_pkg::result_t pend_q, out_res_q;
  logic             out_last_q;

  // shared combinational terms
  logic [CW-1:0]  n_lim;
  logic [6:0]     nregs;
  logic [CW:0]    mid_sum;
  logic [PAW-1:0] mid;
  logic [31:0]    probe_addr;
  logic           s_eq, s_lt, s_empty;
  logic [CW-1:0]  nl, nr;
  logic           f_none, f_same, cur_zero, dead, found;
  logic           dp_big, bp_big;
  logic           cur_bit;
  logic [31:0]    raw_cnt;
  logic [6:0]     slots;
  logic           switch_stack, out_free;
  logic [63:0]    bitmap_d;
  gcsm_pkg::state_e adv_state;

  assign n_lim = ({23'd0, entries_i} > 32'(NumPoints)) ? CW'(NumPoints) : CW'(entries_i);
  assign nregs = ({25'd0, num_regs_i} > 32'(MaxRegs)) ? 7'(MaxRegs) : num_regs_i;
  assign mid_sum = {1'b0, left_q} + {1'b0, rp1_q} - (CW+1)'(1);
  assign mid = mid_sum[PAW:1];
  assign probe_addr = pt_rdata_i[PW-1 -: 32];
  assign s_eq = (pc_q == probe_addr);
  assign s_lt = (pc_q < probe_addr);
  assign nl = s_lt ? left_q : ({1'b0, mid} + CW'(1));
  assign nr = s_lt ? {1'b0, mid} : rp1_q;
  assign s_empty = (nl >= nr);

  assign f_none = stack_q ? ds_rdata_i[gcsm_pkg::FlagStackNone]
                          : ds_rdata_i[gcsm_pkg::FlagRegsNone];
  assign f_same = stack_q ? ds_rdata_i[gcsm_pkg::FlagStackSame]
                          : ds_rdata_i[gcsm_pkg::FlagRegsSame];
  assign cur_zero = (cur_q == '0);
  assign dead  = f_none || (f_same && cur_zero);
  assign found = !f_none && !f_same;

  assign dp_big = ({22'd0, dp_q} >= 32'(DataWords));
  assign bp_big = ({22'd0, bp_q} >= 32'(BaseWords));

  assign cur_bit = sword_q[5'd31 - pos_q[4:0]];
  assign raw_cnt = bs_rdata_i;
  assign slots = raw_cnt[31] ? 7'd0
               : (raw_cnt > 32'(MaxStackSlots)) ? 7'(MaxStackSlots) : raw_cnt[6:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    bitmap_d = bitmap_q;
    if (state_q == gcsm_pkg::S_SCAN_BIT && !stack_q && cur_bit) bitmap_d[idx_q] = 1'b1;
  end

  // end of register part: go on with the stack part from the hit entry
  assign switch_stack = !stack_q &&
      ((state_q == gcsm_pkg::S_RES_CHK && (dead || (found && nregs == 7'd0))) ||
       (state_q == gcsm_pkg::S_SCAN_BIT && cnt_q == 7'd1));

  always_comb begin
    if (cnt_q == 7'd1) begin
      adv_state = stack_q ? gcsm_pkg::S_PUSH_END : gcsm_pkg::S_RES_RDP;
    end else if (pos_q[4:0] == 5'd31) begin
      adv_state = gcsm_pkg::S_SCAN_RD;
    end else begin
      adv_state = gcsm_pkg::S_SCAN_BIT;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gcsm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_opcode_i)
            gcsm_pkg::OpWrIndex: state_d = gcsm_pkg::S_REDUCE;
            gcsm_pkg::OpWrData,
            gcsm_pkg::OpWrBase:  state_d = gcsm_pkg::S_WRITE;
            gcsm_pkg::OpQuery:   state_d = (n_lim == '0) ? gcsm_pkg::S_PUSH_END
                                                         : gcsm_pkg::S_SRCH_RD;
            default:             state_d = gcsm_pkg::S_IDLE;
          endcase
        end
      end
      gcsm_pkg::S_REDUCE:   if (!dp_big && !bp_big) state_d = gcsm_pkg::S_WRITE;
      gcsm_pkg::S_WRITE:    state_d = gcsm_pkg::S_PUSH_END;
      gcsm_pkg::S_SRCH_RD:  state_d = gcsm_pkg::S_SRCH_CMP;
      gcsm_pkg::S_SRCH_CMP: begin
        if (s_eq) state_d = gcsm_pkg::S_RES_RDP;
        else if (s_empty) state_d = gcsm_pkg::S_PUSH_END;
        else state_d = gcsm_pkg::S_SRCH_RD;
      end
      gcsm_pkg::S_RES_RDP:  state_d = gcsm_pkg::S_RES_RDD;
      gcsm_pkg::S_RES_RDD:  state_d = gcsm_pkg::S_RES_CHK;
      gcsm_pkg::S_RES_CHK: begin
        priority if (dead) begin
          state_d = stack_q ? gcsm_pkg::S_PUSH_END : gcsm_pkg::S_RES_RDP;
        end else if (found) begin
          if (stack_q) state_d = gcsm_pkg::S_BASE_RD;
          else state_d = (nregs == 7'd0) ? gcsm_pkg::S_RES_RDP : gcsm_pkg::S_SCAN_RD;
        end else begin
          state_d = gcsm_pkg::S_RES_RDP;
        end
      end
      gcsm_pkg::S_BASE_RD:  state_d = gcsm_pkg::S_BASE_CHK;
      gcsm_pkg::S_BASE_CHK: state_d = (slots == 7'd0) ? gcsm_pkg::S_PUSH_END
                                                      : gcsm_pkg::S_SCAN_RD;
      gcsm_pkg::S_SCAN_RD:  state_d = gcsm_pkg::S_SCAN_LAT;
      gcsm_pkg::S_SCAN_LAT: state_d = gcsm_pkg::S_SCAN_BIT;
      gcsm_pkg::S_SCAN_BIT: state_d = (stack_q && cur_bit) ? gcsm_pkg::S_SCAN_OFF : adv_state;
      gcsm_pkg::S_SCAN_OFF: state_d = gcsm_pkg::S_PUSH_MID;
      gcsm_pkg::S_PUSH_MID: if (out_free) state_d = gcsm_pkg::S_SCAN_ADV;
      gcsm_pkg::S_SCAN_ADV: state_d = adv_state;
      gcsm_pkg::S_PUSH_END: if (out_free) state_d = gcsm_pkg::S_IDLE;
      default:              state_d = gcsm_pkg::S_IDLE;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    in_ready_o = (state_q == gcsm_pkg::S_IDLE);
    pt_we_o    = (state_q == gcsm_pkg::S_WRITE) && (op_q == gcsm_pkg::OpWrIndex) &&
                 ({22'd0, slot_q} < 32'(NumPoints));
    pt_waddr_o = PAW'(slot_q);
    pt_wdata_o = {pc_q, DAW'(dp_q), BAW'(bp_q)};
    ds_we_o    = (state_q == gcsm_pkg::S_WRITE) && (op_q == gcsm_pkg::OpWrData) &&
                 ({22'd0, slot_q} < 32'(DataWords));
    ds_waddr_o = DAW'(slot_q);
    ds_wdata_o = wword_q;
    bs_we_o    = (state_q == gcsm_pkg::S_WRITE) && (op_q == gcsm_pkg::OpWrBase) &&
                 ({22'd0, slot_q} < 32'(BaseWords));
    bs_waddr_o = BAW'(slot_q);
    bs_wdata_o = wword_q;
    pt_raddr_o = (state_q == gcsm_pkg::S_SRCH_RD) ? mid : cur_q;
    ds_raddr_o = (state_q == gcsm_pkg::S_RES_RDD) ? pt_rdata_i[DAW+BAW-1 -: DAW]
                                                  : d_wrap_add(dstart_q, pos_q[7:5]);
    bs_raddr_o = (state_q == gcsm_pkg::S_BASE_RD) ? bstart_q : kaddr_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcsm_pkg::S_IDLE;
      stack_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gcsm_pkg::S_IDLE) stack_q <= 1'b0;
      else if (switch_stack) stack_q <= 1'b1;
      if ((state_q == gcsm_pkg::S_PUSH_MID || state_q == gcsm_pkg::S_PUSH_END) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gcsm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_q     <= in_opcode_i;
          slot_q   <= in_slot_i;
          pc_q     <= in_pc_i;
          wword_q  <= in_word_i;
          dp_q     <= in_data_ptr_i;
          bp_q     <= in_base_ptr_i;
          left_q   <= '0;
          rp1_q    <= n_lim;
          bitmap_q <= '0;
          pend_q   <= '{kind: gcsm_pkg::KindNotFound, reg_bitmap: '0, stack_offset: '0};
        end
      end
      gcsm_pkg::S_REDUCE: begin
        // pointers are kept reduced modulo the store depth
        if (dp_big) dp_q <= dp_q - 10'(DataWords);
        if (bp_big) bp_q <= bp_q - 10'(BaseWords);
      end
      gcsm_pkg::S_WRITE: begin
        pend_q <= '{kind: gcsm_pkg::KindWrAck, reg_bitmap: '0, stack_offset: '0};
      end
      gcsm_pkg::S_SRCH_CMP: begin
        entry_q <= mid;
        cur_q   <= mid;
        left_q  <= nl;
        rp1_q   <= nr;
      end
      gcsm_pkg::S_RES_RDD: begin
        dstart_q <= pt_rdata_i[DAW+BAW-1 -: DAW];
        bstart_q <= pt_rdata_i[BAW-1:0];
      end
      gcsm_pkg::S_RES_CHK: begin
        regs_flag_q <= ds_rdata_i[gcsm_pkg::FlagRegsNone] | ds_rdata_i[gcsm_pkg::FlagRegsSame];
        pos_q <= 8'(DescBits);
        cnt_q <= nregs;
        idx_q <= '0;
        if (!dead && !found) cur_q <= cur_q - PAW'(1);
        if (switch_stack) begin
          cur_q  <= entry_q;
          pend_q <= '{kind: gcsm_pkg::KindRegMap, reg_bitmap: bitmap_d, stack_offset: '0};
        end
      end
      gcsm_pkg::S_BASE_CHK: begin
        pos_q   <= 8'(DescBits) + (regs_flag_q ? 8'd0 : {1'b0, nregs});
        cnt_q   <= slots;
        kaddr_q <= b_wrap_inc(bstart_q);
      end
      gcsm_pkg::S_SCAN_LAT: sword_q <= ds_rdata_i;
      gcsm_pkg::S_SCAN_BIT: begin
        bitmap_q <= bitmap_d;
        if (!(stack_q && cur_bit)) begin
          pos_q   <= pos_q + 8'd1;
          cnt_q   <= cnt_q - 7'd1;
          idx_q   <= idx_q + 6'd1;
          kaddr_q <= b_wrap_inc(kaddr_q);
        end
        if (switch_stack) begin
          cur_q  <= entry_q;
          pend_q <= '{kind: gcsm_pkg::KindRegMap, reg_bitmap: bitmap_d, stack_offset: '0};
        end
      end
      gcsm_pkg::S_SCAN_OFF: new_q <= bs_rdata_i;
      gcsm_pkg::S_PUSH_MID: begin
        if (out_free) begin
          out_res_q  <= pend_q;
          out_last_q <= 1'b0;
          pend_q     <= '{kind: gcsm_pkg::KindStackOff, reg_bitmap: '0, stack_offset: new_q};
        end
      end
      gcsm_pkg::S_SCAN_ADV: begin
        pos_q   <= pos_q + 8'd1;
        cnt_q   <= cnt_q - 7'd1;
        idx_q   <= idx_q + 6'd1;
        kaddr_q <= b_wrap_inc(kaddr_q);
      end
      gcsm_pkg::S_PUSH_END: begin
        if (out_free) begin
          out_res_q  <= pend_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gcsm_pkg::S_SRCH_RD |-> left_q < rp1_q)
    else $error("search probe with an empty range");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcsm_pkg::S_SCAN_BIT || state_q == gcsm_pkg::S_SCAN_ADV) |-> cnt_q != 7'd0)
    else $error("bit scan with nothing left to scan");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gcsm_pkg::S_PUSH_END && out_free |=> state_q == gcsm_pkg::S_IDLE && out_last_q)
    else $error("final item did not close the lookup");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gcsm_pkg::S_PUSH_MID && out_free |=> !out_last_q &&
      out_res_q.kind != gcsm_pkg::KindWrAck && out_res_q.kind != gcsm_pkg::KindNotFound)
    else $error("intermediate item of wrong kind");

endmodule

// ----- rtl/core/gc_stack_map_lookup_decode.sv -----
// gc_stack_map_lookup_decode: top level; configuration registers and the three stores
// depends on gcsm_pkg, gcsm_if, gcsm_ram and gcsm_ctrl
//
//  channel   dir  payload
//  in_ch     in   opcode, slot, pc, word, data_ptr, base_ptr
//  out_ch    out  kind, reg_bitmap, stack_offset, last
//  cfg_ch    in   index (0 num_regs, 1 entries_in_use), data
//
// a write returns one acknowledge item; an index write first reduces its pointers modulo the store depths.
// a query runs a binary search over the point store, walks back over same-as-previous entries, then
// scans the bitmap bits, reading each descriptor word and the base word of each live stack slot.
// one item is in work at a time; the single memory read port of each store sets the pace.
// the result register stalls the sequencer only while a result is waiting to be taken.
// reset returns control and the configuration registers to their defaults; stores need no clearing.
module gc_stack_map_lookup_decode #(
  parameter int unsigned NumPoints     = gcsm_pkg::NumPointsDef,
  parameter int unsigned DataWords     = gcsm_pkg::DataWordsDef,
  parameter int unsigned BaseWords     = gcsm_pkg::BaseWordsDef,
  parameter int unsigned MaxRegs       = gcsm_pkg::MaxRegsDef,
  parameter int unsigned DescBits      = gcsm_pkg::DescBitsDef,
  parameter int unsigned MaxStackSlots = gcsm_pkg::MaxStackSlotsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  gcsm_in_if.sink    in_ch,
  gcsm_out_if.source out_ch,
  gcsm_cfg_if.sink   cfg_ch
);

  localparam int unsigned PAW = $clog2(NumPoints);
  localparam int unsigned DAW = $clog2(DataWords);
  localparam int unsigned BAW = $clog2(BaseWords);
  localparam int unsigned PW  = 32 + DAW + BAW;

  logic [6:0] num_regs_q;
  logic [8:0] entries_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_regs_q <= gcsm_pkg::NumRegsReset;
      entries_q  <= gcsm_pkg::EntriesReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gcsm_pkg::CfgNumRegs:      num_regs_q <= cfg_ch.data[6:0];
        gcsm_pkg::CfgEntriesInUse: entries_q  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic            pt_we, ds_we, bs_we;
  logic [PAW-1:0]  pt_waddr, pt_raddr;
  logic [PW-1:0]   pt_wdata, pt_rdata;
  logic [DAW-1:0]  ds_waddr, ds_raddr;
  logic [BAW-1:0]  bs_waddr, bs_raddr;
  logic [31:0]     ds_wdata, ds_rdata, bs_wdata, bs_rdata;
  gcsm_pkg::result_t res;

  gcsm_ram #(.Width(PW), .Depth(NumPoints)) u_point_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );

  gcsm_ram #(.Width(32), .Depth(DataWords)) u_desc_ram (
    .clk_i, .we_i(ds_we), .waddr_i(ds_waddr), .wdata_i(ds_wdata),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata)
  );

  gcsm_ram #(.Width(32), .Depth(BaseWords)) u_base_ram (
    .clk_i, .we_i(bs_we), .waddr_i(bs_waddr), .wdata_i(bs_wdata),
    .raddr_i(bs_raddr), .rdata_o(bs_rdata)
  );

  gcsm_ctrl #(
    .NumPoints(NumPoints), .DataWords(DataWords), .BaseWords(BaseWords),
    .MaxRegs(MaxRegs), .DescBits(DescBits), .MaxStackSlots(MaxStackSlots)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .in_opcode_i(in_ch.opcode), .in_slot_i(in_ch.slot), .in_pc_i(in_ch.pc),
    .in_word_i(in_ch.word), .in_data_ptr_i(in_ch.data_ptr), .in_base_ptr_i(in_ch.base_ptr),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_res_o(res), .out_last_o(out_ch.last),
    .num_regs_i(num_regs_q), .entries_i(entries_q),
    .pt_we_o(pt_we), .pt_waddr_o(pt_waddr), .pt_wdata_o(pt_wdata),
    .pt_raddr_o(pt_raddr), .pt_rdata_i(pt_rdata),
    .ds_we_o(ds_we), .ds_waddr_o(ds_waddr), .ds_wdata_o(ds_wdata),
    .ds_raddr_o(ds_raddr), .ds_rdata_i(ds_rdata),
    .bs_we_o(bs_we), .bs_waddr_o(bs_waddr), .bs_wdata_o(bs_wdata),
    .bs_raddr_o(bs_raddr), .bs_rdata_i(bs_rdata)
  );

  assign out_ch.kind         = res.kind;
  assign out_ch.reg_bitmap   = res.reg_bitmap;
  assign out_ch.stack_offset = res.stack_offset;

endmodule

// ----- tb/gc_stack_map_lookup_decode_chk.sv -----
`timescale 1ns / 1ps
// gc_stack_map_lookup_decode_chk: watches the item, result and config channels,
// predicts every result and compares; depends on gcsm_pkg and gcsm_if
module gc_stack_map_lookup_decode_chk
  import gcsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gcsm_in_if          in_ch,
  gcsm_out_if         out_ch,
  gcsm_cfg_if         cfg_ch,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct {
    kind_e       kind;
    logic [63:0] reg_bitmap;
    logic [31:0] stack_offset;
    logic        last;
  } lookup_res_t;

  lookup_res_t lookup_q[$];

  logic [6:0]  num_regs_q;
  logic [8:0]  entries_q;
  logic [31:0] pt_addr  [NumPointsDef];
  logic [9:0]  pt_data  [NumPointsDef];
  logic [9:0]  pt_base  [NumPointsDef];
  logic [31:0] desc_mem [DataWordsDef];
  logic [31:0] base_mem [BaseWordsDef];

  assign pending_o = lookup_q.size();

  function automatic logic [31:0] desc_word(int e, int i);
    return desc_mem[(int'(pt_data[e]) + i) % DataWordsDef];
  endfunction

  // bitmap bits are numbered msb-first across the entry's descriptor words
  function automatic logic desc_bit(int e, int pos);
    logic [31:0] w;
    w = desc_word(e, pos >> 5);
    return w[31 - (pos & 31)];
  endfunction

  // follow same-as-previous flags back; 0 when nothing is live
  function automatic logic walk_back(int e, int none_bit, int same_bit, output int src);
    logic [31:0] d;
    src = 0;
    forever begin
      d = desc_word(e, 0);
      if (d[none_bit]) return 1'b0;
      if (!d[same_bit]) begin
        src = e;
        return 1'b1;
      end
      if (e == 0) return 1'b0;
      e--;
    end
  endfunction

  function automatic void push_res(kind_e k, logic [63:0] bm, logic [31:0] off, logic l);
    lookup_res_t r;
    r.kind = k;
    r.reg_bitmap = bm;
    r.stack_offset = off;
    r.last = l;
    lookup_q.push_back(r);
  endfunction

  function automatic void predict_lookup(op_e op, logic [9:0] slot, logic [31:0] pc,
                                         logic [31:0] word, logic [9:0] dp, logic [9:0] bp);
    int n, nregs, lo, hi, mid, entry, src, skip, slots, bb;
    logic hit;
    logic [63:0] bm;
    logic [31:0] d, raw;
    hit = 1'b0;
    bm = '0;
    entry = 0;
    case (op)
      OpWrIndex: begin
        if (slot < NumPointsDef) begin
          pt_addr[slot] = pc;
          pt_data[slot] = dp;
          pt_base[slot] = bp;
        end
        push_res(KindWrAck, '0, '0, 1'b1);
      end
      OpWrData: begin
        if (slot < DataWordsDef) desc_mem[slot] = word;
        push_res(KindWrAck, '0, '0, 1'b1);
      end
      OpWrBase: begin
        if (slot < BaseWordsDef) base_mem[slot] = word;
        push_res(KindWrAck, '0, '0, 1'b1);
      end
      default: begin
        n = (entries_q > NumPointsDef) ? NumPointsDef : int'(entries_q);
        nregs = (num_regs_q > MaxRegsDef) ? MaxRegsDef : int'(num_regs_q);
        lo = 0;
        hi = n - 1;
        while (hi >= lo && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (pc == pt_addr[mid]) begin
            entry = mid;
            hit = 1'b1;
          end else if (pc < pt_addr[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
        if (!hit) begin
          push_res(KindNotFound, '0, '0, 1'b1);
        end else begin
          if (walk_back(entry, FlagRegsNone, FlagRegsSame, src))
            for (int r = 0; r < nregs; r++)
              if (desc_bit(src, DescBitsDef + r)) bm[r] = 1'b1;
          push_res(KindRegMap, bm, '0, 1'b0);
          if (walk_back(entry, FlagStackNone, FlagStackSame, src)) begin
            d = desc_word(src, 0);
            skip = (d[FlagRegsNone] || d[FlagRegsSame]) ? 0 : nregs;
            bb = pt_base[src];
            raw = base_mem[bb % BaseWordsDef];
            if (raw[31]) slots = 0;
            else slots = (raw > MaxStackSlotsDef) ? MaxStackSlotsDef : int'(raw);
            for (int k = 0; k < slots; k++)
              if (desc_bit(src, DescBitsDef + skip + k))
                push_res(KindStackOff, '0, base_mem[(bb + 1 + k) % BaseWordsDef], 1'b0);
          end
          lookup_q[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t w;
    if (!rst_ni) begin
      num_regs_q <= NumRegsReset;
      entries_q  <= EntriesReset;
      errors_o   <= 0;
      lookup_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lookup_q.size() == 0) begin
          report("result item with nothing expected", out_ch.kind, 0);
        end else begin
          w = lookup_q.pop_front();
          if (out_ch.kind !== w.kind) report("kind", out_ch.kind, w.kind);
          if (out_ch.reg_bitmap !== w.reg_bitmap)
            report("reg_bitmap", out_ch.reg_bitmap, w.reg_bitmap);
          if (out_ch.stack_offset !== w.stack_offset)
            report("stack_offset", out_ch.stack_offset, w.stack_offset);
          if (out_ch.last !== w.last) report("last", out_ch.last, w.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CfgNumRegs) num_regs_q <= cfg_ch.data[6:0];
        else entries_q <= cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        predict_lookup(in_ch.opcode, in_ch.slot, in_ch.pc, in_ch.word,
                       in_ch.data_ptr, in_ch.base_ptr);
    end
  end

endmodule

// ----- tb/gc_stack_map_lookup_decode_tb.sv -----
`timescale 1ns / 1ps
// gc_stack_map_lookup_decode_tb: loads the stores, runs directed and random
// items under several idle and stall patterns; depends on gcsm_pkg, gcsm_if and the checker
module gc_stack_map_lookup_decode_tb;
  import gcsm_pkg::*;

  localparam int unsigned CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned errors, pending, cycles;
  int unsigned idle_pct, stall_pct;
  logic [31:0] pcs [NumPointsDef];

  gcsm_in_if  in_ch();
  gcsm_out_if out_ch();
  gcsm_cfg_if cfg_ch();

  gc_stack_map_lookup_decode dut (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_ch (in_ch), .out_ch (out_ch), .cfg_ch (cfg_ch)
  );

  gc_stack_map_lookup_decode_chk chk (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_ch (in_ch), .out_ch (out_ch), .cfg_ch (cfg_ch),
    .errors_o (errors), .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[gc_stack_map_lookup_decode] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_item(op_e op, logic [9:0] slot, logic [31:0] pc, logic [31:0] word,
                           logic [9:0] dp, logic [9:0] bp);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.slot     <= slot;
    in_ch.pc       <= pc;
    in_ch.word     <= word;
    in_ch.data_ptr <= dp;
    in_ch.base_ptr <= bp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop sending and let every expected item arrive, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [8:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_desc();
    logic [31:0] w;
    w = $urandom;
    w[31] = ($urandom_range(3) == 0);
    w[30] = ($urandom_range(3) == 0);
    w[29] = ($urandom_range(3) == 0);
    w[28] = ($urandom_range(3) == 0);
    return w;
  endfunction

  // base words double as slot counts, so keep many of them small
  function automatic logic [31:0] rand_base();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(40);
  endfunction

  task automatic rand_item();
    int sel, s;
    logic [31:0] p;
    sel = $urandom_range(99);
    if (sel < 45) begin
      send_item(OpQuery, $urandom, pcs[$urandom_range(NumPointsDef - 1)], $urandom,
                $urandom, $urandom);
    end else if (sel < 53) begin
      send_item(OpQuery, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 73) begin
      send_item(OpWrData, $urandom, $urandom, rand_desc(), $urandom, $urandom);
    end else if (sel < 85) begin
      send_item(OpWrBase, $urandom, $urandom, rand_base(), $urandom, $urandom);
    end else begin
      s = $urandom_range(99);
      if (s < 15) begin
        send_item(OpWrIndex, $urandom_range(1023, NumPointsDef), $urandom, $urandom,
                  $urandom, $urandom);
      end else begin
        s = $urandom_range(NumPointsDef - 1);
        p = ($urandom_range(99) < 80) ? pcs[s] : $urandom;
        pcs[s] = p;
        send_item(OpWrIndex, s, p, $urandom, $urandom, $urandom);
      end
    end
  endtask

  int unsigned regs_set [8] = '{64, 0, 1, 32, 127, 65, 7, 64};
  int unsigned ents_set [8] = '{256, 0, 1, 255, 300, 511, 128, 256};

  initial begin
    rst_ni = 1'b0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OpWrIndex;
    in_ch.slot = '0;
    in_ch.pc = '0;
    in_ch.word = '0;
    in_ch.data_ptr = '0;
    in_ch.base_ptr = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgNumRegs;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every store so that no lookup touches an unwritten entry
    for (int i = 0; i < DataWordsDef; i++)
      send_item(OpWrData, i, 0, rand_desc(), 0, 0);
    for (int i = 0; i < BaseWordsDef; i++)
      send_item(OpWrBase, i, 0, rand_base(), 0, 0);
    for (int i = 0; i < NumPointsDef; i++) begin
      pcs[i] = i * 64 + 16;
      send_item(OpWrIndex, i, pcs[i], 0, $urandom, $urandom);
    end
    drain();
    cfg_write(CfgNumRegs, 64);
    cfg_write(CfgEntriesInUse, 256);

    // directed: full bitmap wrapping the data store, saturated count, flags, misses
    send_item(OpWrData, 1022, 0, 32'h0FFF_FFFF, 0, 0);
    send_item(OpWrData, 1023, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(OpWrData, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(OpWrData, 1, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(OpWrBase, 1023, 0, 40, 0, 0);
    pcs[0] = 0;
    send_item(OpWrIndex, 0, 0, 0, 1022, 1023);
    send_item(OpQuery, 0, 0, 0, 0, 0);
    send_item(OpWrData, 5, 0, 32'hF000_0000, 0, 0);
    pcs[255] = 32'hFFFF_FFFF;
    send_item(OpWrIndex, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 1023);
    send_item(OpQuery, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(OpWrData, 6, 0, 32'h5000_0000, 0, 0);
    send_item(OpWrIndex, 1, pcs[1], 0, 6, 0);
    send_item(OpQuery, 0, pcs[1], 0, 0, 0);
    send_item(OpWrBase, 1023, 0, 32'h8000_0005, 0, 0);
    send_item(OpQuery, 0, 0, 0, 0, 0);
    // same flags at entry zero: nothing live
    send_item(OpWrData, 1022, 0, 32'h5000_0000, 0, 0);
    send_item(OpQuery, 0, pcs[1], 0, 0, 0);
    send_item(OpWrData, 1022, 0, 32'h0FFF_FFFF, 0, 0);
    send_item(OpWrBase, 1023, 0, 32, 0, 0);
    send_item(OpWrIndex, 1023, 32'hFFFF_FFFF, 0, 10'h3FF, 10'h3FF);
    send_item(OpWrIndex, 256, 1, 0, 0, 0);
    send_item(OpQuery, 0, 1, 0, 0, 0);
    send_item(OpQuery, 0, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(OpQuery, 0, pcs[128], 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(CfgNumRegs, regs_set[ph]);
      cfg_write(CfgEntriesInUse, ents_set[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (int i = 0; i < 47; i++) begin
        if (ph == 3 && i == 23) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        rand_item();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[gc_stack_map_lookup_decode] OK");
    end else begin
      $display("[gc_stack_map_lookup_decode] ERROR");
    end
    $finish;
  end

endmodule
